/* rtl/core/cas_pkg.sv */
`timescale 1ns / 1ps

package cas_pkg;

    // Default sizing
    localparam int MAX_SAMPLES_DEF  = 64;
    localparam int CORDIC_STEPS_DEF = 18;

    // Angle constants, Q16 radians
    localparam int TWO_PI_Q16  = 411775;
    localparam int PI_Q16      = 205887;
    localparam int HALF_PI_Q16 = 102944;
    // CORDIC start value, Q30
    localparam int CORDIC_GAIN_Q30 = 652032874;

    // Datapath widths
    localparam int ANG_W   = 41;   // unsaturated heading, Q16
    localparam int POS_W   = 44;   // unsaturated position, Q16
    localparam int OFS_W   = 46;   // unsaturated offset position, Q16
    localparam int D2_W    = 34;   // unsaturated second derivative, Q24
    localparam int UNIT_W  = 18;   // sin / cos, Q1.16
    localparam int CRD_W   = 34;   // CORDIC x, y, z, Q30
    localparam int LEN_W   = 33;   // run position
    localparam int NUM_W   = 43;   // divider numerator, Q40
    localparam int DIVM_W  = 42;   // numerator magnitude
    localparam int MOD_W   = 43;   // angle reduction compare width
    localparam int MOD_STEPS = 24; // shifts of 2*pi tried by the reduction
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X       = 3'd0,
        CFG_START_Y       = 3'd1,
        CFG_START_HEADING = 3'd2,
        CFG_CURVATURE     = 3'd3,
        CFG_ARC_LENGTH    = 3'd4
    } t_cfg_idx;

    // Shared multiplier operand pairs
    typedef enum logic [2:0] {
        MUL_SK,   // s * kappa
        MUL_SC,   // s * cos
        MUL_SS,   // s * sin
        MUL_OS,   // offset * sin
        MUL_OC,   // offset * cos
        MUL_KS,   // kappa * sin
        MUL_KC    // kappa * cos
    } t_mul_sel;

    // Destination of the registered product
    typedef enum logic [2:0] {
        WR_NONE,
        WR_TH,
        WR_X,
        WR_Y,
        WR_OX,
        WR_OY,
        WR_D2X,
        WR_D2Y
    } t_wr_sel;

    // Controller to datapath
    typedef struct packed {
        logic     load_item;
        logic     sc_start;
        logic     sc_sel;      // 0: start heading, 1: point heading
        logic     sc_store0;
        logic     sc_store;
        t_mul_sel mul_sel;
        t_wr_sel  wr_sel;
        logic     div_start;
        logic     div_store;
        logic     out_load;
        logic     out_last;
        logic     out_trunc;
        logic     step;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic action;
        logic k_zero;
        logic len_zero;
        logic next_in;
        logic sc_done;
        logic div_done;
        logic out_free;
    } t_sts;

    // Arctangent table, Q30
    function automatic logic signed [CRD_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CRD_W-1:0] v;
        case (idx)
            5'd0:  v = 34'sd843314857;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043837;
            5'd3:  v = 34'sd133525159;
            5'd4:  v = 34'sd67021687;
            5'd5:  v = 34'sd33543516;
            5'd6:  v = 34'sd16775851;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194283;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048576;
            5'd11: v = 34'sd524288;
            5'd12: v = 34'sd262144;
            5'd13: v = 34'sd131072;
            5'd14: v = 34'sd65536;
            5'd15: v = 34'sd32768;
            5'd16: v = 34'sd16384;
            5'd17: v = 34'sd8192;
            5'd18: v = 34'sd4096;
            5'd19: v = 34'sd2048;
            5'd20: v = 34'sd1024;
            5'd21: v = 34'sd512;
            5'd22: v = 34'sd256;
            5'd23: v = 34'sd128;
            5'd24: v = 34'sd64;
            5'd25: v = 34'sd32;
            5'd26: v = 34'sd16;
            5'd27: v = 34'sd8;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Clamp a Q16 term to +-1.0
    function automatic logic signed [UNIT_W-1:0] clamp_unit(input logic signed [19:0] v);
        logic signed [UNIT_W-1:0] r;
        if (v > 20'sd65536)
            r = 18'sd65536;
        else if (v < -20'sd65536)
            r = -18'sd65536;
        else
            r = v[UNIT_W-1:0];
        return r;
    endfunction

endpackage

/* rtl/core/cas_sincos.sv */
`timescale 1ns / 1ps

module cas_sincos import cas_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [ANG_W-1:0]  i_angle,
    output logic                     o_done,
    output logic signed [UNIT_W-1:0] o_cos,
    output logic signed [UNIT_W-1:0] o_sin
);

    typedef enum logic [4:0] {
        SC_IDLE = 5'b00001,
        SC_MOD  = 5'b00010,
        SC_FOLD = 5'b00100,
        SC_ROT  = 5'b01000,
        SC_FIN  = 5'b10000
    } t_sc_state;

    localparam logic [4:0] LAST_ROT = 5'(CORDIC_STEPS - 1);

    t_sc_state r_state, n_state;

    logic                    r_neg;
    logic [ANG_W-1:0]        r_rem;
    logic [4:0]              r_j;
    logic [4:0]              r_i;
    logic signed [CRD_W-1:0] r_x, r_y, r_z;
    logic                    r_flip;
    logic                    r_done;
    logic signed [UNIT_W-1:0] r_cos, r_sin;

    // Reduction step: try 2*pi shifted left by j
    logic [MOD_W-1:0] mod_sub;
    assign mod_sub = {2'b00, r_rem} - (MOD_W'(TWO_PI_Q16) << r_j);

    // Fold into [-pi/2, pi/2]
    logic signed [19:0] fold_r0, fold_r1, fold_r2;
    logic               fold_flip;
    always_comb begin
        fold_r0 = {1'b0, r_rem[18:0]};
        if (r_neg && (r_rem != '0))
            fold_r0 = 20'sd411775 - fold_r0;
        fold_r1 = (fold_r0 > 20'sd205887) ? fold_r0 - 20'sd411775 : fold_r0;
        fold_flip = 1'b0;
        fold_r2 = fold_r1;
        if (fold_r1 > 20'sd102944) begin
            fold_r2 = 20'sd205887 - fold_r1;
            fold_flip = 1'b1;
        end else if (fold_r1 < -20'sd102944) begin
            fold_r2 = -20'sd205887 - fold_r1;
            fold_flip = 1'b1;
        end
    end

    // One CORDIC rotation
    logic signed [CRD_W-1:0] rot_xs, rot_ys, rot_atan;
    assign rot_xs   = r_x >>> r_i;
    assign rot_ys   = r_y >>> r_i;
    assign rot_atan = atan_q30(r_i);

    // Round Q30 to Q16 and clamp
    logic signed [CRD_W-1:0] fin_xr, fin_yr;
    logic signed [UNIT_W-1:0] fin_c, fin_s;
    always_comb begin
        fin_xr = (r_x + 34'sd8192) >>> 14;
        fin_yr = (r_y + 34'sd8192) >>> 14;
        fin_c  = clamp_unit(fin_xr[19:0]);
        fin_s  = clamp_unit(fin_yr[19:0]);
    end

    // Sequencing
    always_comb begin
        n_state = r_state;
        case (r_state)
            SC_IDLE: if (i_start) n_state = SC_MOD;
            SC_MOD:  if (r_j == '0) n_state = SC_FOLD;
            SC_FOLD: n_state = SC_ROT;
            SC_ROT:  if (r_i == LAST_ROT) n_state = SC_FIN;
            SC_FIN:  n_state = SC_IDLE;
            default: n_state = SC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == SC_FIN);
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            SC_IDLE: begin
                r_neg <= i_angle[ANG_W-1];
                r_rem <= i_angle[ANG_W-1] ? ANG_W'(-i_angle) : ANG_W'(i_angle);
                r_j   <= 5'(MOD_STEPS - 1);
            end
            SC_MOD: begin
                if (!mod_sub[MOD_W-1])
                    r_rem <= mod_sub[ANG_W-1:0];
                r_j <= r_j - 5'd1;
            end
            SC_FOLD: begin
                r_z    <= CRD_W'(fold_r2) <<< 14;
                r_x    <= CRD_W'(CORDIC_GAIN_Q30);
                r_y    <= '0;
                r_flip <= fold_flip;
                r_i    <= '0;
            end
            SC_ROT: begin
                if (!r_z[CRD_W-1]) begin
                    r_x <= r_x - rot_ys;
                    r_y <= r_y + rot_xs;
                    r_z <= r_z - rot_atan;
                end else begin
                    r_x <= r_x + rot_ys;
                    r_y <= r_y - rot_xs;
                    r_z <= r_z + rot_atan;
                end
                r_i <= r_i + 5'd1;
            end
            SC_FIN: begin
                r_cos <= r_flip ? -fin_c : fin_c;
                r_sin <= fin_s;
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

/* rtl/core/cas_divider.sv */
`timescale 1ns / 1ps

module cas_divider import cas_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num_x,
    input  logic signed [NUM_W-1:0] i_num_y,
    input  logic signed [31:0]      i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_q_x,
    output logic signed [NUM_W-1:0] o_q_y
);

    localparam logic [5:0] LAST_BIT = 6'(DIVM_W - 1);

    logic                    r_busy;
    logic                    r_done;
    logic [5:0]              r_cnt;
    logic [31:0]             r_den;
    logic [DIVM_W-1:0]       r_dvd [2];
    logic [32:0]             r_rem [2];
    logic                    r_qneg [2];
    logic signed [NUM_W-1:0] r_q [2];

    logic signed [NUM_W-1:0] num [2];
    logic [32:0]             rem_sh [2];
    logic [32:0]             rem_sub [2];
    logic                    ge [2];
    logic [DIVM_W-1:0]       q_fin [2];

    assign num[0] = i_num_x;
    assign num[1] = i_num_y;

    // Restoring step per lane, one quotient bit a cycle
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            rem_sh[l]  = {r_rem[l][31:0], r_dvd[l][DIVM_W-1]};
            rem_sub[l] = rem_sh[l] - {1'b0, r_den};
            ge[l]      = (rem_sh[l] >= {1'b0, r_den});
            q_fin[l]   = {r_dvd[l][DIVM_W-2:0], ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == LAST_BIT)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Magnitudes in, signed quotients out, truncated toward zero
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_cnt <= '0;
            r_den <= i_den[31] ? 32'(-i_den) : 32'(i_den);
            for (int l = 0; l < 2; l++) begin
                r_dvd[l]  <= num[l][NUM_W-1] ? DIVM_W'(-num[l]) : DIVM_W'(num[l]);
                r_rem[l]  <= '0;
                r_qneg[l] <= num[l][NUM_W-1] ^ i_den[31];
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            for (int l = 0; l < 2; l++) begin
                r_rem[l] <= ge[l] ? rem_sub[l] : rem_sh[l];
                r_dvd[l] <= q_fin[l];
                if (r_cnt == LAST_BIT)
                    r_q[l] <= r_qneg[l] ? -$signed({1'b0, q_fin[l]})
                                        : $signed({1'b0, q_fin[l]});
            end
        end
    end

    assign o_done = r_done;
    assign o_q_x  = r_q[0];
    assign o_q_y  = r_q[1];

endmodule

/* rtl/core/cas_datapath.sv */
`timescale 1ns / 1ps

module cas_datapath import cas_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    // input item fields
    input  logic                        i_action,
    input  logic signed [31:0]          i_arc_pos,
    input  logic signed [31:0]          i_normal_offset,
    input  logic signed [31:0]          i_sample_step,
    // control
    input  t_cmd                        i_cmd,
    output t_sts                        o_sts,
    // result item
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic signed [31:0]          o_pos_x,
    output logic signed [31:0]          o_pos_y,
    output logic signed [31:0]          o_heading,
    output logic signed [UNIT_W-1:0]    o_dx_ds,
    output logic signed [UNIT_W-1:0]    o_dy_ds,
    output logic signed [31:0]          o_d2x_ds2,
    output logic signed [31:0]          o_d2y_ds2,
    output logic signed [31:0]          o_heading_rate,
    output logic signed [31:0]          o_offset_x,
    output logic signed [31:0]          o_offset_y,
    output logic                        o_last,
    output logic                        o_truncated
);

    // Segment registers
    logic signed [31:0] r_x0, r_y0, r_sh, r_k, r_len_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x0      <= '0;
            r_y0      <= '0;
            r_sh      <= '0;
            r_k       <= '0;
            r_len_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_START_X:       r_x0      <= i_cfg_data;
                CFG_START_Y:       r_y0      <= i_cfg_data;
                CFG_START_HEADING: r_sh      <= i_cfg_data;
                CFG_CURVATURE:     r_k       <= i_cfg_data;
                CFG_ARC_LENGTH:    r_len_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Item registers and run position
    logic                     r_action;
    logic signed [31:0]       r_arc_pos, r_offs, r_step;
    logic signed [LEN_W-1:0]  r_len;
    logic signed [LEN_W:0]    next_len;
    logic [LEN_W:0]           next_abs;
    logic [31:0]              lim;

    assign next_len = (LEN_W+1)'(r_len) + (LEN_W+1)'(r_step);
    assign next_abs = next_len[LEN_W] ? (LEN_W+1)'(-next_len) : (LEN_W+1)'(next_len);
    assign lim      = r_len_cfg[31] ? 32'(-r_len_cfg) : 32'(r_len_cfg);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action  <= i_action;
            r_arc_pos <= i_arc_pos;
            r_offs    <= i_normal_offset;
            r_step    <= i_sample_step;
            r_len     <= '0;
        end else if (i_cmd.step) begin
            r_len <= next_len[LEN_W-1:0];
        end
    end

    // Point registers
    logic signed [ANG_W-1:0]  r_th;
    logic signed [UNIT_W-1:0] r_c, r_s, r_c0, r_s0;
    logic signed [POS_W-1:0]  r_x, r_y;
    logic signed [OFS_W-1:0]  r_ox, r_oy;
    logic signed [D2_W-1:0]   r_d2x, r_d2y;
    logic signed [63:0]       r_prod;

    // Current arc length: inside a run it always fits 32 bits
    logic signed [31:0] cur_s;
    assign cur_s = r_action ? r_len[31:0] : r_arc_pos;

    logic signed [31:0] c_ext, s_ext;
    assign c_ext = {{(32-UNIT_W){r_c[UNIT_W-1]}}, r_c};
    assign s_ext = {{(32-UNIT_W){r_s[UNIT_W-1]}}, r_s};

    // Shared multiplier, product registered
    logic signed [31:0] mul_a, mul_b;
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SK:  begin mul_a = cur_s;  mul_b = r_k;   end
            MUL_SC:  begin mul_a = cur_s;  mul_b = c_ext; end
            MUL_SS:  begin mul_a = cur_s;  mul_b = s_ext; end
            MUL_OS:  begin mul_a = r_offs; mul_b = s_ext; end
            MUL_OC:  begin mul_a = r_offs; mul_b = c_ext; end
            MUL_KS:  begin mul_a = r_k;    mul_b = s_ext; end
            MUL_KC:  begin mul_a = r_k;    mul_b = c_ext; end
            default: begin mul_a = cur_s;  mul_b = r_k;   end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Rounding of the product, negated where the term carries -sin
    logic               prod_neg;
    logic signed [64:0] prod_n, rnd16, rnd24;
    assign prod_neg = (i_cmd.wr_sel == WR_OX) || (i_cmd.wr_sel == WR_D2X);
    assign prod_n   = prod_neg ? -(65'(r_prod)) : 65'(r_prod);
    assign rnd16    = (prod_n + 65'sd32768) >>> 16;
    assign rnd24    = (prod_n + 65'sd8388608) >>> 24;

    // Sine / cosine unit
    logic                     sc_done;
    logic signed [UNIT_W-1:0] sc_cos, sc_sin;

    cas_sincos #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sc_start),
        .i_angle (i_cmd.sc_sel ? r_th : ANG_W'(r_sh)),
        .o_done  (sc_done),
        .o_cos   (sc_cos),
        .o_sin   (sc_sin)
    );

    // Chord divider, both axes at once
    logic signed [UNIT_W:0]  dsin, dcos;
    logic signed [NUM_W-1:0] num_x, num_y, q_x, q_y;
    logic                    div_done;

    assign dsin  = (UNIT_W+1)'(r_s) - (UNIT_W+1)'(r_s0);
    assign dcos  = (UNIT_W+1)'(r_c0) - (UNIT_W+1)'(r_c);
    assign num_x = {dsin, 24'd0};
    assign num_y = {dcos, 24'd0};

    cas_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num_x (num_x),
        .i_num_y (num_y),
        .i_den   (r_k),
        .o_done  (div_done),
        .o_q_x   (q_x),
        .o_q_y   (q_y)
    );

    // Point register updates
    always_ff @(posedge i_clk) begin
        if (i_cmd.sc_store0) begin
            r_c0 <= sc_cos;
            r_s0 <= sc_sin;
        end
        if (i_cmd.sc_store) begin
            r_c <= sc_cos;
            r_s <= sc_sin;
        end
        if (i_cmd.div_store) begin
            r_x <= POS_W'(r_x0) + POS_W'(q_x);
            r_y <= POS_W'(r_y0) + POS_W'(q_y);
        end
        case (i_cmd.wr_sel)
            WR_TH:   r_th  <= ANG_W'(r_sh) + rnd24[ANG_W-1:0];
            WR_X:    r_x   <= POS_W'(r_x0) + rnd16[POS_W-1:0];
            WR_Y:    r_y   <= POS_W'(r_y0) + rnd16[POS_W-1:0];
            WR_OX:   r_ox  <= OFS_W'(r_x) + rnd16[OFS_W-1:0];
            WR_OY:   r_oy  <= OFS_W'(r_y) + rnd16[OFS_W-1:0];
            WR_D2X:  r_d2x <= rnd16[D2_W-1:0];
            WR_D2Y:  r_d2y <= rnd16[D2_W-1:0];
            default: ;
        endcase
    end

    // Output register
    logic r_out_valid;
    logic out_free;
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (i_cmd.out_load)
            r_out_valid <= 1'b1;
        else if (i_out_ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_pos_x     <= sat32(64'(r_x));
            o_pos_y     <= sat32(64'(r_y));
            o_heading   <= sat32(64'(r_th));
            o_last      <= i_cmd.out_last;
            o_truncated <= i_cmd.out_trunc;
            if (r_action) begin
                // run items carry position and heading only
                o_dx_ds        <= '0;
                o_dy_ds        <= '0;
                o_d2x_ds2      <= '0;
                o_d2y_ds2      <= '0;
                o_heading_rate <= '0;
                o_offset_x     <= '0;
                o_offset_y     <= '0;
            end else begin
                o_dx_ds        <= r_c;
                o_dy_ds        <= r_s;
                o_d2x_ds2      <= sat32(64'(r_d2x));
                o_d2y_ds2      <= sat32(64'(r_d2y));
                o_heading_rate <= r_k;
                o_offset_x     <= sat32(64'(r_ox));
                o_offset_y     <= sat32(64'(r_oy));
            end
        end
    end

    assign o_out_valid = r_out_valid;

    // Status
    always_comb begin
        o_sts.action   = r_action;
        o_sts.k_zero   = (r_k == '0);
        o_sts.len_zero = (r_len_cfg == '0);
        o_sts.next_in  = (next_abs < {2'b00, lim});
        o_sts.sc_done  = sc_done;
        o_sts.div_done = div_done;
        o_sts.out_free = out_free;
    end

endmodule

/* rtl/core/cas_ctrl.sv */
`timescale 1ns / 1ps

module cas_ctrl import cas_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    typedef enum logic [17:0] {
        ST_IDLE = 18'b000000000000000001,
        ST_H0   = 18'b000000000000000010,
        ST_H0W  = 18'b000000000000000100,
        ST_MTH  = 18'b000000000000001000,
        ST_WTH  = 18'b000000000000010000,
        ST_SC   = 18'b000000000000100000,
        ST_SCW  = 18'b000000000001000000,
        ST_MLX  = 18'b000000000010000000,
        ST_MLY  = 18'b000000000100000000,
        ST_WLY  = 18'b000000001000000000,
        ST_DV   = 18'b000000010000000000,
        ST_DVW  = 18'b000000100000000000,
        ST_MOX  = 18'b000001000000000000,
        ST_MOY  = 18'b000010000000000000,
        ST_MDX  = 18'b000100000000000000,
        ST_MDY  = 18'b001000000000000000,
        ST_WDY  = 18'b010000000000000000,
        ST_OUT  = 18'b100000000000000000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] cnt_inc;
    logic             at_max;

    assign cnt_inc = r_cnt + CNT_W'(1);
    assign at_max  = (cnt_inc == CNT_W'(MAX_SAMPLES));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.mul_sel = MUL_SK;
        o_cmd.wr_sel  = WR_NONE;
        o_in_ready    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_cnt   = '0;
                    n_state = ST_H0;
                end
            end
            // start heading terms, once per item
            ST_H0: begin
                o_cmd.sc_start = 1'b1;
                n_state = ST_H0W;
            end
            ST_H0W: begin
                if (i_sts.sc_done) begin
                    o_cmd.sc_store0 = 1'b1;
                    n_state = (i_sts.action && i_sts.len_zero) ? ST_IDLE : ST_MTH;
                end
            end
            // heading at s
            ST_MTH: begin
                o_cmd.mul_sel = MUL_SK;
                n_state = ST_WTH;
            end
            ST_WTH: begin
                o_cmd.wr_sel = WR_TH;
                n_state = ST_SC;
            end
            ST_SC: begin
                o_cmd.sc_start = 1'b1;
                o_cmd.sc_sel   = 1'b1;
                n_state = ST_SCW;
            end
            ST_SCW: begin
                if (i_sts.sc_done) begin
                    o_cmd.sc_store = 1'b1;
                    n_state = i_sts.k_zero ? ST_MLX : ST_DV;
                end
            end
            // straight line position
            ST_MLX: begin
                o_cmd.mul_sel = MUL_SC;
                n_state = ST_MLY;
            end
            ST_MLY: begin
                o_cmd.mul_sel = MUL_SS;
                o_cmd.wr_sel  = WR_X;
                n_state = ST_WLY;
            end
            ST_WLY: begin
                o_cmd.wr_sel = WR_Y;
                n_state = i_sts.action ? ST_OUT : ST_MOX;
            end
            // arc position through the divider
            ST_DV: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DVW;
            end
            ST_DVW: begin
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_state = i_sts.action ? ST_OUT : ST_MOX;
                end
            end
            // offset point and second derivatives
            ST_MOX: begin
                o_cmd.mul_sel = MUL_OS;
                n_state = ST_MOY;
            end
            ST_MOY: begin
                o_cmd.mul_sel = MUL_OC;
                o_cmd.wr_sel  = WR_OX;
                n_state = ST_MDX;
            end
            ST_MDX: begin
                o_cmd.mul_sel = MUL_KS;
                o_cmd.wr_sel  = WR_OY;
                n_state = ST_MDY;
            end
            ST_MDY: begin
                o_cmd.mul_sel = MUL_KC;
                o_cmd.wr_sel  = WR_D2X;
                n_state = ST_WDY;
            end
            ST_WDY: begin
                o_cmd.wr_sel = WR_D2Y;
                n_state = ST_OUT;
            end
            // hand the item to the output register
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (!i_sts.action) begin
                        o_cmd.out_last = 1'b1;
                        n_state = ST_IDLE;
                    end else if (!i_sts.next_in || at_max) begin
                        o_cmd.out_last  = 1'b1;
                        o_cmd.out_trunc = i_sts.next_in;
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_cnt   = cnt_inc;
                        n_state = ST_MTH;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* rtl/core/circle_arc_point_sampler.sv */
`timescale 1ns / 1ps
// Evaluate: an item on an arc takes longer than one on a line, from accept to result valid.
// Run: a setup pass, then per sample work that is longer on an arc than on a line, plus output stalls.
// Per point the 18-step CORDIC with its 24-step angle reduction and the 42-step divider dominate the time.
// One item at a time; a finished result waits in the output register while the next works.
// Reset: synchronous, active low; clears control, output valid and the segment registers.

module circle_arc_point_sampler import cas_pkg::*; #(
    parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]              i_cfg_data,
    // input items
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_action,
    input  logic signed [31:0]       i_arc_pos,
    input  logic signed [31:0]       i_normal_offset,
    input  logic signed [31:0]       i_sample_step,
    // result items
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [31:0]       o_pos_x,
    output logic signed [31:0]       o_pos_y,
    output logic signed [31:0]       o_heading,
    output logic signed [UNIT_W-1:0] o_dx_ds,
    output logic signed [UNIT_W-1:0] o_dy_ds,
    output logic signed [31:0]       o_d2x_ds2,
    output logic signed [31:0]       o_d2y_ds2,
    output logic signed [31:0]       o_heading_rate,
    output logic signed [31:0]       o_offset_x,
    output logic signed [31:0]       o_offset_y,
    output logic                     o_last,
    output logic                     o_truncated
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    cas_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cas_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_arc_pos       (i_arc_pos),
        .i_normal_offset (i_normal_offset),
        .i_sample_step   (i_sample_step),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_heading       (o_heading),
        .o_dx_ds         (o_dx_ds),
        .o_dy_ds         (o_dy_ds),
        .o_d2x_ds2       (o_d2x_ds2),
        .o_d2y_ds2       (o_d2y_ds2),
        .o_heading_rate  (o_heading_rate),
        .o_offset_x      (o_offset_x),
        .o_offset_y      (o_offset_y),
        .o_last          (o_last),
        .o_truncated     (o_truncated)
    );

    // An accepted item always keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted again right after an accept");

    // A cut run is flagged only on its final item
    a_trunc_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_truncated) |-> o_last)
        else $error("truncated set on an inner item");

    // Inner items come only from runs, which carry no derivatives
    a_inner_no_deriv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_dx_ds == '0 && o_heading_rate == '0))
        else $error("inner run item carries derivative terms");

endmodule
